// ----- hdl/mcpwm_pkg.sv -----
// Package for the multichannel PWM with kickstart: widths, command codes,
// the per-channel control struct and the kickstart divide helper.
// No dependencies.
package mcpwm_pkg;

  // Number of PWM channels (1..4); channels beyond the register set get no kickstart
  localparam int CHANNELS      = 4;
  localparam int NUM_KICK_REGS = 4;
  localparam int PIN_W         = 4;

  localparam int CMD_W   = 2;
  localparam int CHAN_W  = 2;
  localparam int DUTY_W  = 8;
  localparam int COUNT_W = 8;
  localparam int KICK_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Registered input transaction
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic              count_down_kick;
    logic [CHAN_W-1:0] channel;
    logic [DUTY_W-1:0] duty;
  } in_item_t;

  // Per-channel operation for the cycle an item is processed
  typedef struct packed {
    logic               tick_zero;  // tick leaving count zero
    logic               tick_run;   // any other tick
    logic               dec;        // countdown decrement flag
    logic               set;        // set duty on this channel
    logic               clear;      // clear all
    logic [DUTY_W-1:0]  duty;       // new duty for set
    logic [COUNT_W-1:0] count_next; // advanced period counter
  } chan_op_t;

  // Kickstart load: time/100, or time/25 when the old duty was zero.
  // time*41 >> 12 and time*41 >> 10 are exact for 8-bit time.
  function automatic logic [KICK_W-1:0] kick_load(input logic [KICK_W-1:0] kt,
                                                  input logic old_zero);
    logic [KICK_W+5:0] prod;
    prod = {1'b0, kt, 5'b0} + {3'b0, kt, 3'b0} + {6'b0, kt};
    if (old_zero) begin
      kick_load = {4'b0, prod[13:10]};
    end else begin
      kick_load = {6'b0, prod[13:12]};
    end
  endfunction

endpackage

// ----- hdl/mcpwm_if.sv -----
// Valid/ready channel interfaces for the PWM block: input items and results.
// Depends on mcpwm_pkg.
interface mcpwm_in_if import mcpwm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic              count_down_kick;
  logic [CHAN_W-1:0] channel;
  logic [DUTY_W-1:0] duty;

  modport source (output valid, command, count_down_kick, channel, duty, input ready);
  modport sink   (input valid, command, count_down_kick, channel, duty, output ready);
endinterface

interface mcpwm_out_if import mcpwm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIN_W-1:0] pin_levels;

  modport source (output valid, pin_levels, input ready);
  modport sink   (input valid, pin_levels, output ready);
endinterface

// ----- hdl/multichannel_pwm_with_kickstart_unit.sv -----
// Top level of the multichannel PWM with kickstart: input register, period
// counter, kickstart registers, channel array and result register.
// Depends on mcpwm_pkg, mcpwm_if and mcpwm_chan.

// Each input transaction yields exactly one result transaction carrying the
// pin levels after the command. A transaction is registered on entry and
// then processed by the period counter and the per-channel comparators and
// countdowns, whose result lands in the output register: one item per clock
// sustained while the output side takes each result. The input side keeps
// accepting while a result waits, as long as the output register is free or
// being emptied in the same cycle. Kickstart times are written through
// cfg_we/cfg_index/cfg_data; write them only while the block is idle.
module multichannel_pwm_with_kickstart_unit import mcpwm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  mcpwm_in_if.sink              in_ch,
  mcpwm_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                s1_valid;
  in_item_t            s1;
  logic                s1_fire;
  logic [COUNT_W-1:0]  period_count;
  logic [COUNT_W-1:0]  count_next;
  logic [KICK_W-1:0]   kick_time [NUM_KICK_REGS];
  logic [CHANNELS-1:0] level_vec;
  logic [CHANNELS-1:0] level_next_vec;
  logic [PIN_W-1:0]    pins_next;
  logic [PIN_W-1:0]    pins_now;
  logic                out_valid;
  logic [PIN_W-1:0]    out_pins;

  // Handshake: stage 1 moves on when the output register is free or being taken
  assign s1_fire      = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || s1_fire;
  assign out_ch.valid = out_valid;
  assign out_ch.pin_levels = out_pins;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      s1.command         <= in_ch.command;
      s1.count_down_kick <= in_ch.count_down_kick;
      s1.channel         <= in_ch.channel;
      s1.duty            <= in_ch.duty;
    end
  end

  // Kickstart time registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_KICK_REGS; i++) begin
        kick_time[i] <= '0;
      end
    end else if (cfg_we && int'(cfg_index) < CHANNELS) begin
      kick_time[cfg_index] <= cfg_data[KICK_W-1:0];
    end
  end

  // Period counter
  assign count_next = period_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_count <= '0;
    end else if (s1_fire && s1.command == CMD_TICK) begin
      period_count <= count_next;
    end
  end

  // Channel array
  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    chan_op_t          op;
    logic [KICK_W-1:0] kt;

    always_comb begin
      op.tick_zero  = s1_fire && s1.command == CMD_TICK && period_count == '0;
      op.tick_run   = s1_fire && s1.command == CMD_TICK && period_count != '0;
      op.dec        = s1.count_down_kick;
      op.set        = s1_fire && s1.command == CMD_SET && int'(s1.channel) == g;
      op.clear      = s1_fire && s1.command == CMD_CLEAR;
      op.duty       = s1.duty;
      op.count_next = count_next;
    end

    if (g < NUM_KICK_REGS) begin : g_kt
      assign kt = kick_time[g];
    end else begin : g_nokt
      assign kt = '0;
    end

    mcpwm_chan u_chan (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .kick_time  (kt),
      .level      (level_vec[g]),
      .level_next (level_next_vec[g])
    );
  end

  // Map channel levels onto the fixed-width pin field
  for (genvar p = 0; p < PIN_W; p++) begin : g_pin
    if (p < CHANNELS) begin : g_on
      assign pins_next[p] = level_next_vec[p];
      assign pins_now[p]  = level_vec[p];
    end else begin : g_off
      assign pins_next[p] = 1'b0;
      assign pins_now[p]  = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire) begin
      out_pins <= pins_next;
    end
  end

  // Assertions
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_ch.valid)
    else $error("processed transaction produced no result");

  a_result_matches_levels: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_ch.pin_levels == pins_now)
    else $error("result differs from registered pin levels");

  a_clear_drops_pins: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1.command == CMD_CLEAR |=> level_vec == '0)
    else $error("clear left a pin high");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !(s1_valid && out_valid && !out_ch.ready))
    else $error("input accepted while stage 1 is blocked");

endmodule

// ----- hdl/mcpwm_chan.sv -----
// One PWM channel: duty, kickstart countdown and pin level registers.
// Depends on mcpwm_pkg.
module mcpwm_chan import mcpwm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  chan_op_t          op,
  input  logic [KICK_W-1:0] kick_time,
  output logic              level,
  output logic              level_next
);

  logic [DUTY_W-1:0] duty;
  logic [DUTY_W-1:0] duty_next;
  logic [KICK_W-1:0] countdown;
  logic [KICK_W-1:0] countdown_next;
  logic [KICK_W-1:0] cd_dec;

  // Next-state logic for the channel
  always_comb begin
    duty_next      = duty;
    countdown_next = countdown;
    level_next     = level;
    cd_dec         = (op.dec && countdown != '0) ? countdown - 1'b1 : countdown;
    if (op.clear) begin
      duty_next      = '0;
      countdown_next = '0;
      level_next     = 1'b0;
    end else if (op.tick_zero) begin
      level_next = (duty != '0);
    end else if (op.tick_run) begin
      countdown_next = cd_dec;
      if (cd_dec == '0 && duty == op.count_next) begin
        level_next = 1'b0;
      end
    end else if (op.set && op.duty != duty) begin
      duty_next = op.duty;
      if (kick_time != '0 && op.duty > duty) begin
        countdown_next = kick_load(kick_time, duty == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty      <= '0;
      countdown <= '0;
      level     <= 1'b0;
    end else begin
      duty      <= duty_next;
      countdown <= countdown_next;
      level     <= level_next;
    end
  end

endmodule
